FILE: rtl/core/pidt_pkg.sv
// ----------------------------------------------------------------------------
// Process-id table package
// Shared constants, opcode and result codes, slot entry and request types.
// ----------------------------------------------------------------------------
package pidt_pkg;

    localparam int SLOTS     = 128;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int ID_W      = 15;
    localparam int ID_LOW    = 2;
    localparam int ID_HIGH   = 32767;
    localparam int BOOT_ID   = 1;
    localparam int BOOT_SLOT = BOOT_ID % SLOTS;

    localparam logic [4:0] SG_HUP  = 5'd1;
    localparam logic [4:0] SG_INT  = 5'd2;
    localparam logic [4:0] SG_KILL = 5'd9;
    localparam logic [4:0] SG_TERM = 5'd15;
    localparam logic [4:0] SG_STOP = 5'd17;
    localparam logic [4:0] SG_CONT = 5'd19;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_UNALLOC = 3'd1,
        OP_DETACH  = 3'd2,
        OP_EXIT    = 3'd3,
        OP_JOIN    = 3'd4,
        OP_QUERY   = 3'd5,
        OP_SETF    = 3'd6,
        OP_GETF    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        RC_OK     = 3'd0,
        RC_FULL   = 3'd1,
        RC_INVAL  = 3'd2,
        RC_NOSUCH = 3'd3,
        RC_DEADLK = 3'd4,
        RC_PEND   = 3'd5
    } rc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOK,
        ST_SCAN,
        ST_SWEEP,
        ST_FIN_RD,
        ST_FIN_CK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] parent;
        logic            exited;
        logic [31:0]     value;
        logic [4:0]      signal;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        op_t                opcode;
        logic [ID_W-1:0]    caller_pid;
        logic signed [15:0] target_pid;
        logic signed [31:0] exit_value;
        logic               detach_children;
        logic               no_hang;
        logic [4:0]         signal_num;
    } req_t;

    typedef struct packed {
        rc_t                code;
        logic [ID_W-1:0]    pid;
        logic signed [31:0] value;
        logic [4:0]         flag;
        logic               wake;
    } result_t;

endpackage

FILE: rtl/core/process_id_table_top.sv
// ----------------------------------------------------------------------------
// Process-id table top level
// Request channel in, one result per request out through an output register.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  request   in_valid / in_ready  opcode, caller_pid, target_pid, exit_value,
//                                 detach_children, no_hang, signal_num
//  result    out_valid/ out_ready result_code, result_pid, result_value,
//                                 result_flag, wake_stopped
//
// Steps: a lookup request passes dispatch, look and done, and one rejected at
// dispatch goes straight to done; allocate steps over each candidate id whose
// slot is occupied (the wrap from the top id back to the lowest id skips slots
// 0 and 1); exit with detach sweeps the slot RAM at one slot per cycle.
// The single RAM read port sets this sequencing.
// Reset: the table holds only the boot entry right after reset; no clearing
// pass is needed since the slot valid bits live in flip-flops.
// Stalls: a request is taken whenever the engine is idle, even while the
// previous result still sits in the output register.
// ----------------------------------------------------------------------------
module process_id_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [14:0] caller_pid,
    input  logic signed [15:0] target_pid,
    input  logic signed [31:0] exit_value,
    input  logic        detach_children,
    input  logic        no_hang,
    input  logic [4:0]  signal_num,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_code,
    output logic [14:0] result_pid,
    output logic signed [31:0] result_value,
    output logic [4:0]  result_flag,
    output logic        wake_stopped
);
    import pidt_pkg::*;

    req_t    req;
    result_t res;
    result_t out_reg, out_next;
    logic    res_valid;
    logic    res_ready;
    logic    out_valid_reg, out_valid_next;

    // pack the request fields for the engine
    always_comb
    begin
        req.opcode          = op_t'(opcode);
        req.caller_pid      = caller_pid;
        req.target_pid      = target_pid;
        req.exit_value      = exit_value;
        req.detach_children = detach_children;
        req.no_hang         = no_hang;
        req.signal_num      = signal_num;
    end

    pidt_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: advance when empty or being drained, else hold
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_code  = out_reg.code;
    assign result_pid   = out_reg.pid;
    assign result_value = out_reg.value;
    assign result_flag  = out_reg.flag;
    assign wake_stopped = out_reg.wake;

endmodule

FILE: rtl/core/pidt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pidt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/pidt_engine.sv
// ----------------------------------------------------------------------------
// Process-id table engine
// Sequencer around the slot RAM: lookup, allocation scan and detach sweep.
// ----------------------------------------------------------------------------
module pidt_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pidt_pkg::req_t   req,
    output logic             res_valid,
    input  logic             res_ready,
    output pidt_pkg::result_t res
);
    import pidt_pkg::*;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    result_t             res_reg, res_next;
    logic [SLOTS-1:0]    used_reg, used_next;
    logic                boot_reg, boot_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [ID_W-1:0]     nid_reg, nid_next;
    logic [ID_W-1:0]     cand_reg, cand_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SLOT_W-1:0]   raddr_reg, raddr_next;

    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    entry_t              wr_data;
    logic [SLOT_W-1:0]   rd_addr;
    entry_t              rd_data;
    entry_t              ent;
    entry_t              boot_ent;
    logic signed [15:0]  key;
    logic [SLOT_W-1:0]   key_slot;
    logic                hit;
    logic [SLOT_W-1:0]   cand_slot;
    logic [ID_W-1:0]     cand_inc;
    logic                sig_wakes;

    pidt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        boot_ent        = '0;
        boot_ent.id     = ID_W'(BOOT_ID);
        ent       = (boot_reg && (raddr_reg == SLOT_W'(BOOT_SLOT))) ? boot_ent : rd_data;
        key       = (req_reg.opcode == OP_EXIT) ? {1'b0, req_reg.caller_pid}
                                                : req_reg.target_pid;
        key_slot  = key[SLOT_W-1:0];
        hit       = used_reg[raddr_reg] && ({1'b0, ent.id} == key);
        cand_slot = cand_reg[SLOT_W-1:0];
        cand_inc  = (cand_reg == ID_W'(ID_HIGH)) ? ID_W'(ID_LOW) : cand_reg + 1'b1;
        sig_wakes = (req_reg.signal_num == SG_HUP) || (req_reg.signal_num == SG_INT) ||
                    (req_reg.signal_num == SG_KILL) || (req_reg.signal_num == SG_TERM) ||
                    (req_reg.signal_num == SG_CONT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= SLOTS'(1) << BOOT_SLOT;
            boot_reg  <= 1'b1;
            live_reg  <= CNT_W'(1);
            nid_reg   <= ID_W'(ID_LOW);
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            boot_reg  <= boot_next;
            live_reg  <= live_next;
            nid_reg   <= nid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        res_reg   <= res_next;
        cand_reg  <= cand_next;
        cnt_reg   <= cnt_next;
        raddr_reg <= raddr_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        used_next  = used_reg;
        boot_next  = boot_reg;
        live_next  = live_reg;
        nid_next   = nid_reg;
        cand_next  = cand_reg;
        cnt_next   = cnt_reg;
        raddr_next = raddr_reg;
        rd_addr    = key_slot;
        wr_en      = 1'b0;
        wr_addr    = raddr_reg;
        wr_data    = ent;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next   = req;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                res_next   = '0;
                raddr_next = key_slot;
                state_next = ST_LOOK;
                unique case (req_reg.opcode)
                    OP_ALLOC:
                    begin
                        cand_next = nid_reg;
                        if (req_reg.caller_pid == '0)
                        begin
                            res_next.code = RC_INVAL;
                            state_next    = ST_DONE;
                        end
                        else if (live_reg == CNT_W'(SLOTS))
                        begin
                            res_next.code = RC_FULL;
                            state_next    = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_UNALLOC:
                    begin
                        if (req_reg.target_pid < 16'(ID_LOW))
                        begin
                            res_next.code = RC_INVAL;
                            state_next    = ST_DONE;
                        end
                    end
                    OP_DETACH:
                    begin
                        if (req_reg.target_pid <= 16'(BOOT_ID))
                        begin
                            res_next.code = RC_INVAL;
                            state_next    = ST_DONE;
                        end
                    end
                    OP_JOIN:
                    begin
                        if (req_reg.target_pid <= 16'(BOOT_ID))
                        begin
                            res_next.code = RC_INVAL;
                            state_next    = ST_DONE;
                        end
                        else if (req_reg.target_pid == {1'b0, req_reg.caller_pid})
                        begin
                            res_next.code = RC_DEADLK;
                            state_next    = ST_DONE;
                        end
                    end
                    default:
                    begin
                        // exit keys on the caller, the rest on the target
                        if (key <= 16'sd0)
                        begin
                            res_next.code = RC_NOSUCH;
                            state_next    = ST_DONE;
                        end
                    end
                endcase
            end

            ST_LOOK:
            begin
                state_next = ST_DONE;
                if (!hit)
                begin
                    res_next.code = RC_NOSUCH;
                end
                else
                begin
                    unique case (req_reg.opcode)
                        OP_UNALLOC:
                        begin
                            if (ent.exited || (ent.parent != req_reg.caller_pid))
                            begin
                                res_next.code = RC_INVAL;
                            end
                            else
                            begin
                                used_next[raddr_reg] = 1'b0;
                                live_next            = live_reg - 1'b1;
                            end
                        end
                        OP_DETACH:
                        begin
                            if ((ent.parent == '0) || (ent.parent != req_reg.caller_pid))
                            begin
                                res_next.code = RC_INVAL;
                            end
                            else if (ent.exited)
                            begin
                                used_next[raddr_reg] = 1'b0;
                                live_next            = live_reg - 1'b1;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_data.parent = '0;
                            end
                        end
                        OP_EXIT:
                        begin
                            wr_data.exited = 1'b1;
                            wr_data.value  = req_reg.exit_value;
                            if (req_reg.detach_children)
                            begin
                                wr_en      = 1'b1;
                                cnt_next   = '0;
                                state_next = ST_SWEEP;
                            end
                            else if (ent.parent == '0)
                            begin
                                used_next[raddr_reg] = 1'b0;
                                live_next            = live_reg - 1'b1;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                            end
                        end
                        OP_JOIN:
                        begin
                            if (ent.parent == '0)
                            begin
                                res_next.code = RC_INVAL;
                            end
                            else if (!ent.exited)
                            begin
                                res_next.code = req_reg.no_hang ? RC_OK : RC_PEND;
                            end
                            else
                            begin
                                res_next.pid         = req_reg.target_pid[ID_W-1:0];
                                res_next.value       = ent.value;
                                used_next[raddr_reg] = 1'b0;
                                live_next            = live_reg - 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            res_next.pid = ent.parent;
                        end
                        OP_SETF:
                        begin
                            if (!ent.exited)
                            begin
                                wr_data.signal = req_reg.signal_num;
                                if (ent.signal == SG_STOP)
                                begin
                                    wr_en         = sig_wakes;
                                    res_next.wake = sig_wakes;
                                end
                                else
                                begin
                                    wr_en = 1'b1;
                                end
                            end
                        end
                        OP_GETF:
                        begin
                            res_next.flag = ent.signal;
                        end
                        default:
                        begin
                            res_next.code = RC_INVAL;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (!used_reg[cand_slot])
                begin
                    wr_en                = 1'b1;
                    wr_addr              = cand_slot;
                    wr_data              = '0;
                    wr_data.id           = cand_reg;
                    wr_data.parent       = req_reg.caller_pid;
                    used_next[cand_slot] = 1'b1;
                    live_next            = live_reg + 1'b1;
                    nid_next             = cand_inc;
                    res_next.pid         = cand_reg;
                    state_next           = ST_DONE;
                end
                else
                begin
                    cand_next = cand_inc;
                end
            end

            ST_SWEEP:
            begin
                // read slot cnt while checking slot cnt-1
                rd_addr    = cnt_reg[SLOT_W-1:0];
                raddr_next = cnt_reg[SLOT_W-1:0];
                cnt_next   = cnt_reg + 1'b1;
                if ((cnt_reg != '0) && used_reg[raddr_reg] &&
                    (ent.parent == req_reg.caller_pid))
                begin
                    if (ent.exited)
                    begin
                        used_next[raddr_reg] = 1'b0;
                        live_next            = live_reg - 1'b1;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_data.parent = '0;
                    end
                end
                if (cnt_reg == CNT_W'(SLOTS))
                begin
                    state_next = ST_FIN_RD;
                end
            end

            ST_FIN_RD:
            begin
                raddr_next = key_slot;
                state_next = ST_FIN_CK;
            end

            ST_FIN_CK:
            begin
                if (hit && (ent.parent == '0))
                begin
                    used_next[raddr_reg] = 1'b0;
                    live_next            = live_reg - 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en && (wr_addr == SLOT_W'(BOOT_SLOT)))
        begin
            boot_next = 1'b0;
        end
    end

    assign res = res_reg;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process-id table regression bench
// Drives opcode requests through the valid/ready channel, predicts each
// result with a behavioral copy of the id table and compares every result
// field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import pidt_pkg::*;

    localparam int NUM_RANDOM = 1500;
    localparam int NUM_SLOTS = 128;

    typedef struct packed {
        op_t                opcode;
        logic [14:0]        caller_pid;
        logic signed [15:0] target_pid;
        logic signed [31:0] exit_value;
        logic               detach_children;
        logic               no_hang;
        logic [4:0]         signal_num;
    } request_t;

    typedef struct packed {
        rc_t         code;
        logic [14:0] pid;
        logic [31:0] value;
        logic [4:0]  flag;
        logic        wake;
    } answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [2:0] opcode;
    logic [14:0] caller_pid;
    logic signed [15:0] target_pid;
    logic signed [31:0] exit_value;
    logic detach_children;
    logic no_hang;
    logic [4:0] signal_num;
    logic out_valid;
    logic out_ready;
    logic [2:0] result_code;
    logic [14:0] result_pid;
    logic signed [31:0] result_value;
    logic [4:0] result_flag;
    logic wake_stopped;

    process_id_table_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .caller_pid(caller_pid), .target_pid(target_pid),
        .exit_value(exit_value), .detach_children(detach_children),
        .no_hang(no_hang), .signal_num(signal_num),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_code(result_code), .result_pid(result_pid),
        .result_value(result_value), .result_flag(result_flag),
        .wake_stopped(wake_stopped)
    );

    // Shadow copy of the id table.
    logic        tbl_used   [NUM_SLOTS];
    logic [14:0] tbl_id     [NUM_SLOTS];
    logic [14:0] tbl_parent [NUM_SLOTS];
    logic        tbl_exited [NUM_SLOTS];
    logic [31:0] tbl_value  [NUM_SLOTS];
    logic [4:0]  tbl_signal [NUM_SLOTS];
    int unsigned tbl_next;
    int unsigned tbl_live;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int mismatch_count = 0;
    bit sender_paused = 0;
    int hold_cycles = 0;
    bit hold_request = 0;

    function automatic int lookup_slot(int t);
        int s;
        if (t <= 0)
            return -1;
        s = t % NUM_SLOTS;
        if (tbl_used[s] && tbl_id[s] == t[14:0])
            return s;
        return -1;
    endfunction

    function automatic void release_slot(int s);
        tbl_used[s] = 0;
        tbl_id[s] = '0;
        tbl_parent[s] = '0;
        tbl_exited[s] = 0;
        tbl_value[s] = '0;
        tbl_signal[s] = '0;
        if (tbl_live > 0)
            tbl_live--;
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_used[i] = 0;
            tbl_id[i] = '0;
            tbl_parent[i] = '0;
            tbl_exited[i] = 0;
            tbl_value[i] = '0;
            tbl_signal[i] = '0;
        end
        tbl_used[BOOT_SLOT] = 1;
        tbl_id[BOOT_SLOT] = 15'(BOOT_ID);
        tbl_next = ID_LOW;
        tbl_live = 1;
    endfunction

    // Apply one request to the shadow table and return its answer.
    function automatic answer_t apply_request(request_t r);
        answer_t a;
        int t;
        int s;
        int unsigned cand;
        int unsigned steps;
        a = '0;
        a.code = RC_OK;
        t = r.target_pid;
        case (r.opcode)
            OP_ALLOC:
            begin
                if (r.caller_pid == 0)
                    a.code = RC_INVAL;
                else if (tbl_live >= NUM_SLOTS)
                    a.code = RC_FULL;
                else
                begin
                    cand = tbl_next;
                    steps = 0;
                    while (tbl_used[cand % NUM_SLOTS] && steps < ID_HIGH - ID_LOW + 1)
                    begin
                        cand++;
                        if (cand > ID_HIGH)
                            cand = ID_LOW;
                        steps++;
                    end
                    if (tbl_used[cand % NUM_SLOTS])
                        a.code = RC_FULL;
                    else
                    begin
                        s = cand % NUM_SLOTS;
                        tbl_used[s] = 1;
                        tbl_id[s] = cand[14:0];
                        tbl_parent[s] = r.caller_pid;
                        tbl_exited[s] = 0;
                        tbl_value[s] = '0;
                        tbl_signal[s] = '0;
                        tbl_live++;
                        tbl_next = (cand + 1 > ID_HIGH) ? ID_LOW : cand + 1;
                        a.pid = cand[14:0];
                    end
                end
            end
            OP_UNALLOC:
            begin
                s = lookup_slot(t);
                if (t < ID_LOW || t > ID_HIGH)
                    a.code = RC_INVAL;
                else if (s < 0)
                    a.code = RC_NOSUCH;
                else if (tbl_exited[s] || tbl_parent[s] != r.caller_pid)
                    a.code = RC_INVAL;
                else
                    release_slot(s);
            end
            OP_DETACH:
            begin
                s = lookup_slot(t);
                if (t <= BOOT_ID)
                    a.code = RC_INVAL;
                else if (s < 0)
                    a.code = RC_NOSUCH;
                else if (tbl_parent[s] == 0 || tbl_parent[s] != r.caller_pid)
                    a.code = RC_INVAL;
                else
                begin
                    tbl_parent[s] = '0;
                    if (tbl_exited[s])
                        release_slot(s);
                end
            end
            OP_EXIT:
            begin
                s = lookup_slot(int'(r.caller_pid));
                if (s < 0)
                    a.code = RC_NOSUCH;
                else
                begin
                    tbl_exited[s] = 1;
                    tbl_value[s] = r.exit_value;
                    if (r.detach_children)
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (tbl_used[i] && tbl_parent[i] == r.caller_pid)
                            begin
                                tbl_parent[i] = '0;
                                if (tbl_exited[i])
                                    release_slot(i);
                            end
                    if (tbl_used[s] && tbl_id[s] == r.caller_pid && tbl_parent[s] == 0)
                        release_slot(s);
                end
            end
            OP_JOIN:
            begin
                s = lookup_slot(t);
                if (t <= BOOT_ID)
                    a.code = RC_INVAL;
                else if (t == int'(r.caller_pid))
                    a.code = RC_DEADLK;
                else if (s < 0)
                    a.code = RC_NOSUCH;
                else if (tbl_parent[s] == 0)
                    a.code = RC_INVAL;
                else if (!tbl_exited[s])
                    a.code = r.no_hang ? RC_OK : RC_PEND;
                else
                begin
                    a.pid = t[14:0];
                    a.value = tbl_value[s];
                    release_slot(s);
                end
            end
            OP_QUERY:
            begin
                s = lookup_slot(t);
                if (s < 0)
                    a.code = RC_NOSUCH;
                else
                    a.pid = tbl_parent[s];
            end
            OP_SETF:
            begin
                s = lookup_slot(t);
                if (s < 0)
                    a.code = RC_NOSUCH;
                else if (!tbl_exited[s])
                begin
                    if (tbl_signal[s] == SG_STOP)
                    begin
                        if (r.signal_num inside {SG_HUP, SG_INT, SG_KILL, SG_TERM, SG_CONT})
                        begin
                            a.wake = 1;
                            tbl_signal[s] = r.signal_num;
                        end
                    end
                    else
                        tbl_signal[s] = r.signal_num;
                end
            end
            default:
            begin
                s = lookup_slot(t);
                if (s < 0)
                    a.code = RC_NOSUCH;
                else
                    a.flag = tbl_signal[s];
            end
        endcase
        return a;
    endfunction

    // Pick an id that is live most of the time, so requests get past lookup.
    function automatic logic [14:0] pick_live_id();
        int s;
        for (int k = 0; k < 8; k++)
        begin
            s = $urandom_range(NUM_SLOTS - 1);
            if (tbl_used[s])
                return tbl_id[s];
        end
        return 15'($urandom_range(2, 300));
    endfunction

    // Random request, mostly aimed at ids the table actually holds. The
    // shadow table here tracks what has been queued, not what was checked.
    function automatic request_t random_request();
        request_t r;
        int pick;
        r.opcode = op_t'($urandom_range(7));
        pick = $urandom_range(99);
        r.caller_pid = (pick < 60) ? pick_live_id() :
                       (pick < 70) ? 15'd1 :
                       (pick < 75) ? 15'd0 : 15'($urandom);
        pick = $urandom_range(99);
        r.target_pid = (pick < 70) ? 16'(pick_live_id()) :
                       (pick < 80) ? 16'($urandom) :
                       (pick < 85) ? -16'sd1 : 16'($urandom_range(0, 2));
        r.exit_value = $urandom;
        r.detach_children = 1'($urandom_range(1));
        r.no_hang = 1'($urandom_range(1));
        pick = $urandom_range(99);
        r.signal_num = (pick < 30) ? SG_STOP : 5'($urandom);
        // Bias toward allocation so the table fills and drains.
        if ($urandom_range(99) < 25)
            r.opcode = OP_ALLOC;
        return r;
    endfunction

    function automatic request_t make_request(op_t op, logic [14:0] caller,
                                              logic signed [15:0] target);
        request_t r;
        r = '0;
        r.opcode = op;
        r.caller_pid = caller;
        r.target_pid = target;
        r.exit_value = 32'h8000_0000;
        r.signal_num = 5'd31;
        return r;
    endfunction

    // Queue a request and its prediction together.
    task automatic post_request(request_t r);
        pending_requests.push_back(r);
        expected_answers.push_back(apply_request(r));
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("process_id_table_top regression: fail");
        $finish;
    end

    // Driver: hold each request until accepted, insert random gaps.
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            opcode <= '0;
            caller_pid <= '0;
            target_pid <= '0;
            exit_value <= '0;
            detach_children <= 0;
            no_hang <= 0;
            signal_num <= '0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            // Previous request (if any) has been taken this edge.
            if (gap_left > 0 || sender_paused || pending_requests.size() == 0)
            begin
                in_valid <= 0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                request_t r;
                r = pending_requests.pop_front();
                in_valid <= 1;
                opcode <= r.opcode;
                caller_pid <= r.caller_pid;
                target_pid <= r.target_pid;
                exit_value <= r.exit_value;
                detach_children <= r.detach_children;
                no_hang <= r.no_hang;
                signal_num <= r.signal_num;
                gap_left <= ($urandom_range(99) < 60) ? 0 :
                            ($urandom_range(99) < 90) ? $urandom_range(1, 3) :
                                                        $urandom_range(10, 60);
            end
        end
    end

    // Receiver back-pressure: random short stalls, a few longer ones, and
    // one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
            hold_cycles <= 0;
        end
        else if (hold_request && hold_cycles == 0)
        begin
            hold_cycles <= 600;
            out_ready <= 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= (hold_cycles == 1);
        end
        else if ($urandom_range(999) < 4)
        begin
            hold_cycles <= $urandom_range(10, 60);
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) < 70) ? 1'b1 : ($urandom_range(99) < 97);
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: code %0d pid %0d", result_code, result_pid);
            end
            else
            begin
                answer_t e;
                e = expected_answers.pop_front();
                if (result_code !== e.code || result_pid !== e.pid ||
                    result_value !== e.value || result_flag !== e.flag ||
                    wake_stopped !== e.wake)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp code %0d pid %0d val %h flag %0d wake %0d,",
                                  " got code %0d pid %0d val %h flag %0d wake %0d"},
                                 e.code, e.pid, e.value, e.flag, e.wake, result_code,
                                 result_pid, result_value, result_flag, wake_stopped);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        request_t r;
        rst_n = 0;
        reset_table();
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // Directed: allocate from boot, extremes, every opcode and corner.
        post_request(make_request(OP_ALLOC, 15'd0, 16'sd0));        // caller zero
        post_request(make_request(OP_ALLOC, 15'd1, 16'sd0));        // gets id 2
        post_request(make_request(OP_ALLOC, 15'd2, 16'sd0));        // id 3, child of 2
        post_request(make_request(OP_ALLOC, 15'h7FFF, 16'sd0));     // id 4, max caller
        post_request(make_request(OP_QUERY, 15'd0, 16'sd3));
        post_request(make_request(OP_QUERY, 15'd0, -16'sd1));       // negative target
        post_request(make_request(OP_UNALLOC, 15'd0, 16'sd1));      // below range
        post_request(make_request(OP_UNALLOC, 15'd0, 16'sh7FFF));   // missing
        post_request(make_request(OP_UNALLOC, 15'd9, 16'sd3));      // not the parent
        post_request(make_request(OP_DETACH, 15'd0, 16'sd1));       // boot target
        post_request(make_request(OP_JOIN, 15'd3, 16'sd3));         // self join
        post_request(make_request(OP_JOIN, 15'd2, 16'sd3));         // pending
        r = make_request(OP_JOIN, 15'd2, 16'sd3);
        r.no_hang = 1;
        post_request(r);                                            // no-hang
        r = make_request(OP_SETF, 15'd0, 16'sd3);
        r.signal_num = SG_STOP;
        post_request(r);
        post_request(make_request(OP_SETF, 15'd0, 16'sd3));         // ignored while stopped
        r.signal_num = SG_CONT;
        post_request(r);                                            // wakes
        post_request(make_request(OP_GETF, 15'd0, 16'sd3));
        r = make_request(OP_EXIT, 15'd3, 16'sd0);
        r.exit_value = 32'h7FFF_FFFF;
        post_request(r);
        post_request(make_request(OP_SETF, 15'd0, 16'sd3));         // exited target
        post_request(make_request(OP_JOIN, 15'd2, 16'sd3));         // completes
        post_request(make_request(OP_DETACH, 15'h7FFF, 16'sd4));    // detach by owner
        post_request(make_request(OP_DETACH, 15'h7FFF, 16'sd4));    // already detached
        r = make_request(OP_EXIT, 15'd2, 16'sd0);
        r.detach_children = 1;
        post_request(r);                                            // own parent is boot
        post_request(make_request(OP_EXIT, 15'd500, 16'sd0));       // caller missing

        // Fill the table to full, then random traffic.
        for (int i = 0; i < 130; i++)
            post_request(make_request(OP_ALLOC, 15'd1, 16'sd0));
        wait (pending_requests.size() == 0);

        // Hold the receiver off while the sender keeps offering requests.
        hold_request = 1;
        for (int i = 0; i < 10; i++)
            post_request(random_request());
        wait (hold_cycles != 0);
        hold_request = 0;

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            post_request(random_request());
            if (n == NUM_RANDOM / 2)
            begin
                // Pause the sender until everything issued has come back.
                wait (pending_requests.size() == 0);
                sender_paused = 1;
                wait (expected_answers.size() == 0);
                sender_paused = 0;
            end
            while (pending_requests.size() > 8)
                @(posedge clk);
        end
        wait (pending_requests.size() == 0 && expected_answers.size() == 0);
        repeat (200) @(posedge clk);

        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("process_id_table_top regression: pass");
        else
            $display("process_id_table_top regression: fail");
        $finish;
    end
endmodule
